@@ design/tru_pkg.sv @@
`default_nettype none
package tru_pkg;

    localparam int TIME_BITS     = 40;
    localparam int FRAC_BITS     = 16;
    localparam int BASE_BITS     = 32;
    localparam int RATE_BITS     = 40;
    localparam int WIN_BITS      = 32;
    localparam int AVG_BITS      = 56;
    localparam int WEIGHT_BITS   = 16;
    localparam int RUN_BITS      = 8;
    localparam int PKT_BITS      = 16;
    localparam int CFG_ADDR_BITS = 8;
    localparam int CFG_DATA_BITS = 40;
    localparam int RULE_BITS     = 2;

    localparam int ACC_BITS = 96;
    localparam int OPB_BITS = 64;
    localparam int REM_BITS = 46;
    localparam int CNT_BITS = 7;

    localparam logic [CFG_ADDR_BITS-1:0] REG_EWMA_WEIGHT  = 8'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_THRESH   = 8'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH_THRESH  = 8'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ADD_STEP     = 8'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DEC_WEIGHT   = 8'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HYPER_THRESH = 8'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PACKET_BYTES = 8'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INITIAL_RATE = 8'd7;

    localparam logic [RULE_BITS-1:0] RULE_LOW_INC  = 2'd0;
    localparam logic [RULE_BITS-1:0] RULE_HIGH_DEC = 2'd1;
    localparam logic [RULE_BITS-1:0] RULE_GRAD_INC = 2'd2;
    localparam logic [RULE_BITS-1:0] RULE_GRAD_DEC = 2'd3;

    localparam logic [WEIGHT_BITS-1:0] EWMA_WEIGHT_RST = 16'd1311;
    localparam logic [TIME_BITS-1:0]   LOW_THRESH_RST  = 40'd50000;
    localparam logic [TIME_BITS-1:0]   HIGH_THRESH_RST = 40'd500000;
    localparam logic [RATE_BITS-1:0]   ADD_STEP_RST    = 40'd10000000;
    localparam logic [WEIGHT_BITS-1:0] DEC_WEIGHT_RST  = 16'd52429;
    localparam logic [RUN_BITS-1:0]    HYPER_RST       = 8'd5;
    localparam logic [PKT_BITS-1:0]    PACKET_RST      = 16'd1460;
    localparam logic [RATE_BITS-1:0]   RATE_INIT       = 40'd1000000000;

    localparam logic [TIME_BITS-1:0] MAG_LIMIT = {1'b0, {(TIME_BITS-1){1'b1}}};
    localparam logic [FRAC_BITS:0]   FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int                   EPS_Q     = ((2**FRAC_BITS) + 500000) / 1000000;
    localparam logic [32:0]          GRAD_MAX  = {1'b1, 32'd0};
    localparam logic [29:0]          NS_PER_S  = 30'd1000000000;
    localparam logic [WIN_BITS-1:0]  WIN_MIN   = 32'd256;
    localparam logic [WIN_BITS-1:0]  WIN_FLOOR = 32'd282;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] ewma_weight;
        logic [TIME_BITS-1:0]   low_threshold_ns;
        logic [TIME_BITS-1:0]   high_threshold_ns;
        logic [RATE_BITS-1:0]   additive_step_bps;
        logic [WEIGHT_BITS-1:0] decrease_weight;
        logic [RUN_BITS-1:0]    hyper_threshold;
        logic [PKT_BITS-1:0]    packet_bytes;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_MUL = 2'b01,
        OP_DIV = 2'b10
    } unit_op_t;

    typedef struct packed {
        logic                start;
        unit_op_t            op;
        logic [REM_BITS-1:0] rem;
        logic [ACC_BITS-1:0] opa;
        logic [OPB_BITS-1:0] opb;
        logic [CNT_BITS-1:0] count;
    } unit_cmd_t;

    typedef struct packed {
        logic                done;
        logic [ACC_BITS-1:0] result;
    } unit_rsp_t;

endpackage
`default_nettype wire

@@ design/tru_ack_if.sv @@
`default_nettype none
interface tru_ack_if import tru_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] rtt_ns;
    logic [TIME_BITS-1:0] signal_ns;
    logic [TIME_BITS-1:0] now_ns;
    logic [BASE_BITS-1:0] base_rtt_ns;

    modport source (output valid, rtt_ns, signal_ns, now_ns, base_rtt_ns, input ready);
    modport sink (input valid, rtt_ns, signal_ns, now_ns, base_rtt_ns, output ready);
endinterface
`default_nettype wire

@@ design/tru_res_if.sv @@
`default_nettype none
interface tru_res_if import tru_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [RATE_BITS-1:0] rate_bps;
    logic [WIN_BITS-1:0]  window_q8;
    logic [RULE_BITS-1:0] rule_taken;

    modport source (output valid, rate_bps, window_q8, rule_taken, input ready);
    modport sink (input valid, rate_bps, window_q8, rule_taken, output ready);
endinterface
`default_nettype wire

@@ design/tru_cfg_if.sv @@
`default_nettype none
interface tru_cfg_if import tru_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

@@ design/tru_cfg.sv @@
`default_nettype none
module tru_cfg import tru_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tru_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.addr)
                REG_EWMA_WEIGHT:  regs_next.ewma_weight       = cfg.data[WEIGHT_BITS-1:0];
                REG_LOW_THRESH:   regs_next.low_threshold_ns  = cfg.data[TIME_BITS-1:0];
                REG_HIGH_THRESH:  regs_next.high_threshold_ns = cfg.data[TIME_BITS-1:0];
                REG_ADD_STEP:     regs_next.additive_step_bps = cfg.data[RATE_BITS-1:0];
                REG_DEC_WEIGHT:   regs_next.decrease_weight   = cfg.data[WEIGHT_BITS-1:0];
                REG_HYPER_THRESH: regs_next.hyper_threshold   = cfg.data[RUN_BITS-1:0];
                REG_PACKET_BYTES: regs_next.packet_bytes      = cfg.data[PKT_BITS-1:0];
                // initial rate writes are ignored; reset loads RATE_INIT
                REG_INITIAL_RATE: regs_next = regs_reg;
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ewma_weight       <= EWMA_WEIGHT_RST;
            regs_reg.low_threshold_ns  <= LOW_THRESH_RST;
            regs_reg.high_threshold_ns <= HIGH_THRESH_RST;
            regs_reg.additive_step_bps <= ADD_STEP_RST;
            regs_reg.decrease_weight   <= DEC_WEIGHT_RST;
            regs_reg.hyper_threshold   <= HYPER_RST;
            regs_reg.packet_bytes      <= PACKET_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule
`default_nettype wire

@@ design/tru_unit.sv @@
`default_nettype none
module tru_unit import tru_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_cmd_t cmd,
    output unit_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    unit_op_t            op_reg, op_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic [ACC_BITS-1:0] opa_reg, opa_next;
    logic [OPB_BITS-1:0] opb_reg, opb_next;
    logic [REM_BITS-1:0] rem_reg, rem_next;

    logic [REM_BITS:0]   trial;
    logic                ge;

    assign trial      = {rem_reg, opa_reg[ACC_BITS-1]};
    assign ge         = {{(OPB_BITS-REM_BITS-1){1'b0}}, trial} >= opb_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        rem_next  = rem_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = cmd.count;
            acc_next  = '0;
            opa_next  = cmd.opa;
            opb_next  = cmd.opb;
            rem_next  = cmd.rem;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            opa_next = {opa_reg[ACC_BITS-2:0], 1'b0};
            case (op_reg)
                OP_MUL:
                begin
                    if (opb_reg[0])
                    begin
                        acc_next = acc_reg + opa_reg;
                    end
                    opb_next = {1'b0, opb_reg[OPB_BITS-1:1]};
                end
                OP_DIV:
                begin
                    acc_next = {acc_reg[ACC_BITS-2:0], ge};
                    if (ge)
                    begin
                        rem_next = REM_BITS'(trial - opb_reg[REM_BITS:0]);
                    end
                    else
                    begin
                        rem_next = trial[REM_BITS-1:0];
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        rem_reg <= rem_next;
    end

endmodule
`default_nettype wire

@@ design/timely_rate_update.sv @@
// RTT-gradient rate controller, one update per acknowledgment.
// ack (sink): rtt_ns, signal_ns, now_ns, base_rtt_ns; taken when valid and ready.
// result (source): rate_bps, window_q8, rule_taken; one result per ack.
// cfg (sink): addr/data register writes, always ready; write only while idle.
// ack.ready is high only while the sequencer is idle. All multiplies and
// divides go through one shift-add / restoring-divide unit, one bit a cycle,
// so the time from an ack transaction to result valid is set by that unit and
// depends on the rule taken. The time since the last update needs a divide
// only when it is positive and below base_rtt_ns. The sequencer takes no new
// ack until it has handed its result to the output register.
// The result sits in an output register; a new ack is accepted while it waits.
// If the receiver still stalls when the next result is ready, the sequencer
// holds it until the output register frees.
// Reset loads all config registers to their defaults and the rate to 1 Gbit/s;
// the first ack after reset sees a zero signal difference.
`default_nettype none
module timely_rate_update import tru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tru_ack_if.sink    ack,
    tru_res_if.source  result,
    tru_cfg_if.sink    cfg
);

    typedef enum logic [17:0] {
        ST_IDLE = 18'h00001,
        ST_PREP = 18'h00002,
        ST_DIFF = 18'h00004,
        ST_EWMA = 18'h00008,
        ST_DFS  = 18'h00010,
        ST_DFW  = 18'h00020,
        ST_RULE = 18'h00040,
        ST_INCW = 18'h00080,
        ST_RATW = 18'h00100,
        ST_MW   = 18'h00200,
        ST_KW   = 18'h00400,
        ST_GRW  = 18'h00800,
        ST_DECW = 18'h01000,
        ST_CAP  = 18'h02000,
        ST_WPW  = 18'h04000,
        ST_DENW = 18'h08000,
        ST_WINW = 18'h10000,
        ST_OUTW = 18'h20000
    } state_t;

    localparam logic [CNT_BITS-1:0] CNT_W16  = CNT_BITS'(WEIGHT_BITS);
    localparam logic [CNT_BITS-1:0] CNT_F    = CNT_BITS'(FRAC_BITS);
    localparam logic [CNT_BITS-1:0] CNT_DF   = CNT_BITS'(FRAC_BITS + 1);
    localparam logic [CNT_BITS-1:0] CNT_GRAD = CNT_BITS'(AVG_BITS - 1);
    localparam logic [CNT_BITS-1:0] CNT_K    = CNT_BITS'(33 + WEIGHT_BITS);
    localparam logic [CNT_BITS-1:0] CNT_RATE = CNT_BITS'(RATE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_PKT  = CNT_BITS'(PKT_BITS);
    localparam logic [CNT_BITS-1:0] CNT_WIN  = CNT_BITS'(RATE_BITS + TIME_BITS + 5);

    cfg_t      regs;
    unit_cmd_t cmd;
    unit_rsp_t rsp;

    state_t               state_reg, state_next;
    logic                 seen_reg, seen_next;
    logic [TIME_BITS-1:0] prev_reg, prev_next;
    logic [AVG_BITS-1:0]  avg_reg, avg_next;
    logic [RUN_BITS-1:0]  run_reg, run_next;
    logic [RATE_BITS-1:0] cur_reg, cur_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic                 ovalid_reg, ovalid_next;

    logic [TIME_BITS-1:0] rtt_reg, rtt_next;
    logic [TIME_BITS-1:0] sig_reg, sig_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [BASE_BITS-1:0] base_reg, base_next;
    logic                 tneg_reg, tneg_next;
    logic [AVG_BITS-2:0]  tmag_reg, tmag_next;
    logic                 dneg_reg, dneg_next;
    logic [FRAC_BITS:0]   df_reg, df_next;
    logic [RULE_BITS-1:0] rule_reg, rule_next;
    logic [RATE_BITS-1:0] rate_reg, rate_next;
    logic [79:0]          prod_reg, prod_next;
    logic [WIN_BITS-1:0]  win_reg, win_next;
    logic [RATE_BITS-1:0] orate_reg, orate_next;
    logic [WIN_BITS-1:0]  owin_reg, owin_next;
    logic [RULE_BITS-1:0] orule_reg, orule_next;

    logic [TIME_BITS-1:0] prev_e;
    logic                 neg;
    logic [TIME_BITS-1:0] mag;
    logic [TIME_BITS-1:0] magc;
    logic [AVG_BITS:0]    tgt;
    logic [AVG_BITS:0]    avg_x;
    logic [AVG_BITS:0]    d1;
    logic [AVG_BITS:0]    d2;
    logic [TIME_BITS-1:0] tdiff;
    logic [RATE_BITS-1:0] inc;
    logic [RATE_BITS+2:0] inc5;
    logic [RATE_BITS+3:0] rsum;
    logic [56:0]          dec;
    logic [54:0]          quo;
    logic [RATE_BITS-1:0] half;
    logic [RATE_BITS-1:0] rate_f;
    logic [84:0]          wq;
    logic [WIN_BITS-1:0]  wsat;
    logic [PKT_BITS-1:0]  pkt;
    logic [BASE_BITS-1:0] base_in;

    tru_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tru_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    assign ack.ready         = (state_reg == ST_IDLE);
    assign result.valid      = ovalid_reg;
    assign result.rate_bps   = orate_reg;
    assign result.window_q8  = owin_reg;
    assign result.rule_taken = orule_reg;

    assign base_in = (ack.base_rtt_ns == '0) ? BASE_BITS'(1) : ack.base_rtt_ns;
    assign pkt     = (regs.packet_bytes == '0) ? PKT_BITS'(1) : regs.packet_bytes;

    always_comb
    begin
        state_next  = state_reg;
        seen_next   = seen_reg;
        prev_next   = prev_reg;
        avg_next    = avg_reg;
        run_next    = run_reg;
        cur_next    = cur_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg;
        rtt_next    = rtt_reg;
        sig_next    = sig_reg;
        now_next    = now_reg;
        base_next   = base_reg;
        tneg_next   = tneg_reg;
        tmag_next   = tmag_reg;
        dneg_next   = dneg_reg;
        df_next     = df_reg;
        rule_next   = rule_reg;
        rate_next   = rate_reg;
        prod_next   = prod_reg;
        win_next    = win_reg;
        orate_next  = orate_reg;
        owin_next   = owin_reg;
        orule_next  = orule_reg;

        cmd       = '0;
        cmd.op    = OP_MUL;

        prev_e = seen_reg ? prev_reg : sig_reg;
        neg    = sig_reg < prev_e;
        mag    = neg ? (prev_e - sig_reg) : (sig_reg - prev_e);
        magc   = (mag > MAG_LIMIT) ? MAG_LIMIT : mag;
        tgt    = tneg_reg ? ((AVG_BITS+1)'(0) - {2'b00, tmag_reg}) : {2'b00, tmag_reg};
        avg_x  = {avg_reg[AVG_BITS-1], avg_reg};
        d1     = tgt - avg_x;
        d2     = avg_x - tgt;
        tdiff  = now_reg - last_reg;
        inc    = rsp.result[FRAC_BITS +: RATE_BITS];
        inc5   = ((rule_reg == RULE_GRAD_INC) && (run_reg >= regs.hyper_threshold))
                 ? ({1'b0, inc, 2'b00} + {3'b000, inc}) : {3'b000, inc};
        rsum   = {4'b0000, cur_reg} + {1'b0, inc5};
        dec    = rsp.result[88:32];
        quo    = rsp.result[54:0];
        half   = {1'b0, cur_reg[RATE_BITS-1:1]};
        rate_f = (rate_reg < half) ? half : rate_reg;
        wq     = rsp.result[84:0];
        wsat   = (wq[84:WIN_BITS] != '0) ? {WIN_BITS{1'b1}} : wq[WIN_BITS-1:0];

        if (result.valid && result.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (ack.valid)
                begin
                    rtt_next   = ack.rtt_ns;
                    sig_next   = ack.signal_ns;
                    now_next   = ack.now_ns;
                    base_next  = base_in;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                tneg_next = neg;
                tmag_next = {magc[TIME_BITS-2:0], {FRAC_BITS{1'b0}}};
                if (neg)
                begin
                    if (run_reg != {RUN_BITS{1'b1}})
                    begin
                        run_next = run_reg + 1'b1;
                    end
                end
                else
                begin
                    run_next = '0;
                end
                seen_next  = 1'b1;
                prev_next  = sig_reg;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dneg_next  = d1[AVG_BITS];
                cmd.start  = 1'b1;
                cmd.op     = OP_MUL;
                cmd.opa    = ACC_BITS'(d1[AVG_BITS] ? d2 : d1);
                cmd.opb    = OPB_BITS'(regs.ewma_weight);
                cmd.count  = CNT_W16;
                state_next = ST_EWMA;
            end
            ST_EWMA:
            begin
                if (rsp.done)
                begin
                    if (dneg_reg)
                    begin
                        avg_next = avg_reg - rsp.result[WEIGHT_BITS +: AVG_BITS];
                    end
                    else
                    begin
                        avg_next = avg_reg + rsp.result[WEIGHT_BITS +: AVG_BITS];
                    end
                    state_next = ST_DFS;
                end
            end
            ST_DFS:
            begin
                if (now_reg <= last_reg)
                begin
                    df_next    = '0;
                    state_next = ST_RULE;
                end
                else if (tdiff >= TIME_BITS'(base_reg))
                begin
                    df_next    = FRAC_ONE;
                    state_next = ST_RULE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    cmd.rem    = REM_BITS'(tdiff);
                    cmd.opb    = OPB_BITS'(base_reg);
                    cmd.count  = CNT_F;
                    state_next = ST_DFW;
                end
            end
            ST_DFW:
            begin
                if (rsp.done)
                begin
                    df_next    = {1'b0, rsp.result[FRAC_BITS-1:0]};
                    state_next = ST_RULE;
                end
            end
            ST_RULE:
            begin
                cmd.start = 1'b1;
                if (rtt_reg < regs.low_threshold_ns)
                begin
                    rule_next  = RULE_LOW_INC;
                    cmd.op     = OP_MUL;
                    cmd.opa    = ACC_BITS'(regs.additive_step_bps);
                    cmd.opb    = OPB_BITS'(df_reg);
                    cmd.count  = CNT_DF;
                    state_next = ST_INCW;
                end
                else if (rtt_reg > regs.high_threshold_ns)
                begin
                    rule_next  = RULE_HIGH_DEC;
                    cmd.op     = OP_DIV;
                    cmd.rem    = REM_BITS'(rtt_reg - regs.high_threshold_ns);
                    cmd.opb    = OPB_BITS'(rtt_reg);
                    cmd.count  = CNT_F;
                    state_next = ST_RATW;
                end
                else if (avg_reg[AVG_BITS-1] || (avg_reg == '0))
                begin
                    rule_next  = RULE_GRAD_INC;
                    cmd.op     = OP_MUL;
                    cmd.opa    = ACC_BITS'(regs.additive_step_bps);
                    cmd.opb    = OPB_BITS'(df_reg);
                    cmd.count  = CNT_DF;
                    state_next = ST_INCW;
                end
                else
                begin
                    cmd.op     = OP_DIV;
                    cmd.opa    = {avg_reg[AVG_BITS-2:0], {(ACC_BITS-AVG_BITS+1){1'b0}}};
                    cmd.opb    = OPB_BITS'(base_reg);
                    cmd.count  = CNT_GRAD;
                    state_next = ST_GRW;
                end
            end
            ST_INCW:
            begin
                if (rsp.done)
                begin
                    rate_next  = (rsum[RATE_BITS+3:RATE_BITS] != '0) ? {RATE_BITS{1'b1}}
                                                                       : rsum[RATE_BITS-1:0];
                    state_next = ST_CAP;
                end
            end
            ST_RATW:
            begin
                if (rsp.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    cmd.opa    = ACC_BITS'(df_reg);
                    cmd.opb    = OPB_BITS'(rsp.result[FRAC_BITS-1:0]);
                    cmd.count  = CNT_F;
                    state_next = ST_MW;
                end
            end
            ST_MW:
            begin
                if (rsp.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    cmd.opa    = ACC_BITS'(rsp.result[FRAC_BITS +: FRAC_BITS]);
                    cmd.opb    = OPB_BITS'(regs.decrease_weight);
                    cmd.count  = CNT_W16;
                    state_next = ST_KW;
                end
            end
            ST_GRW:
            begin
                if (rsp.done)
                begin
                    cmd.start = 1'b1;
                    if (quo <= 55'(EPS_Q))
                    begin
                        rule_next  = RULE_GRAD_INC;
                        cmd.op     = OP_MUL;
                        cmd.opa    = ACC_BITS'(regs.additive_step_bps);
                        cmd.opb    = OPB_BITS'(df_reg);
                        cmd.count  = CNT_DF;
                        state_next = ST_INCW;
                    end
                    else
                    begin
                        rule_next  = RULE_GRAD_DEC;
                        cmd.op     = OP_MUL;
                        cmd.opa    = (quo > 55'(GRAD_MAX)) ? ACC_BITS'(GRAD_MAX)
                                                           : ACC_BITS'(quo);
                        cmd.opb    = OPB_BITS'(regs.decrease_weight);
                        cmd.count  = CNT_W16;
                        state_next = ST_KW;
                    end
                end
            end
            ST_KW:
            begin
                if (rsp.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    cmd.opa    = ACC_BITS'(cur_reg);
                    cmd.opb    = OPB_BITS'(rsp.result[48:0]);
                    cmd.count  = CNT_K;
                    state_next = ST_DECW;
                end
            end
            ST_DECW:
            begin
                if (rsp.done)
                begin
                    rate_next  = (dec >= 57'(cur_reg)) ? '0 : RATE_BITS'(57'(cur_reg) - dec);
                    state_next = ST_CAP;
                end
            end
            ST_CAP:
            begin
                rate_next  = rate_f;
                cur_next   = rate_f;
                last_next  = now_reg;
                cmd.start  = 1'b1;
                cmd.op     = OP_MUL;
                cmd.opa    = ACC_BITS'(rtt_reg);
                cmd.opb    = OPB_BITS'(rate_f);
                cmd.count  = CNT_RATE;
                state_next = ST_WPW;
            end
            ST_WPW:
            begin
                if (rsp.done)
                begin
                    prod_next  = rsp.result[79:0];
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    cmd.opa    = ACC_BITS'(NS_PER_S);
                    cmd.opb    = OPB_BITS'(pkt);
                    cmd.count  = CNT_PKT;
                    state_next = ST_DENW;
                end
            end
            ST_DENW:
            begin
                if (rsp.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    cmd.opa    = {prod_reg, 16'd0};
                    cmd.opb    = OPB_BITS'(rsp.result[45:0]);
                    cmd.count  = CNT_WIN;
                    state_next = ST_WINW;
                end
            end
            ST_WINW:
            begin
                if (rsp.done)
                begin
                    win_next   = (wsat <= WIN_MIN) ? WIN_FLOOR : wsat;
                    state_next = ST_OUTW;
                end
            end
            ST_OUTW:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    orate_next  = rate_reg;
                    owin_next   = win_reg;
                    orule_next  = rule_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seen_reg   <= 1'b0;
            prev_reg   <= '0;
            avg_reg    <= '0;
            run_reg    <= '0;
            cur_reg    <= RATE_INIT;
            last_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seen_reg   <= seen_next;
            prev_reg   <= prev_next;
            avg_reg    <= avg_next;
            run_reg    <= run_next;
            cur_reg    <= cur_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rtt_reg   <= rtt_next;
        sig_reg   <= sig_next;
        now_reg   <= now_next;
        base_reg  <= base_next;
        tneg_reg  <= tneg_next;
        tmag_reg  <= tmag_next;
        dneg_reg  <= dneg_next;
        df_reg    <= df_next;
        rule_reg  <= rule_next;
        rate_reg  <= rate_next;
        prod_reg  <= prod_next;
        win_reg   <= win_next;
        orate_reg <= orate_next;
        owin_reg  <= owin_next;
        orule_reg <= orule_next;
    end

endmodule
`default_nettype wire

@@ tb/tb_timely_rate_update.sv @@
`default_nettype none
module tb_timely_rate_update;
    import tru_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int STALL_CYCLES   = 3000;
    localparam int TAIL_CYCLES    = 400;
    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 8'hff;
    localparam logic [63:0] RATE_SAT = (64'd1 << RATE_BITS) - 1;
    localparam logic [63:0] MAX40    = (64'd1 << TIME_BITS) - 1;
    localparam logic [63:0] MAG_CAP  = (64'd1 << 39) - 1;

    typedef struct packed {
        logic [TIME_BITS-1:0] rtt;
        logic [TIME_BITS-1:0] sig;
        logic [TIME_BITS-1:0] now;
        logic [BASE_BITS-1:0] base;
    } ack_item_t;

    typedef struct packed {
        logic [RATE_BITS-1:0] rate;
        logic [WIN_BITS-1:0]  win;
        logic [RULE_BITS-1:0] rule;
    } rate_result_t;

    logic clk;
    logic rst_n;

    tru_ack_if ack_ch();
    tru_res_if res_ch();
    tru_cfg_if cfg_ch();

    timely_rate_update dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ack    (ack_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // register copies
    logic [63:0] w_ewma, thr_low, thr_high, add_step, w_dec, hyper_thr, pkt_bytes, init_rate;
    // controller state copy
    logic               have_first;
    logic [63:0]        prev_sig;
    logic signed [63:0] avg_diff;
    logic [63:0]        neg_run;
    logic [63:0]        cur_rate;
    logic [63:0]        last_time;

    ack_item_t    pending_acks[$];
    rate_result_t rate_exp_q[$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           stall_req;
    int           stall_seen;
    int           stall_left;
    int           idle_cycles;

    logic [63:0] gen_now;
    logic [63:0] gen_rtt;
    int          gen_dir;

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] frac_quot(logic [63:0] n, logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, n} << FRAC_BITS) / {64'd0, d};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] r, logic [63:0] inc);
        return (inc > RATE_SAT - r) ? RATE_SAT : r + inc;
    endfunction

    function automatic logic [63:0] shrink(logic [63:0] r, logic [63:0] k);
        logic [63:0] dec;
        dec = mul_shift(r, k, 16 + FRAC_BITS);
        return (dec >= r) ? 64'd0 : r - dec;
    endfunction

    function automatic rate_result_t timely_predict(ack_item_t a);
        logic [63:0]        rtt, sig, now, base, mag, dm, corr, df, prior_rate, rate;
        logic [63:0]        ratio, m, grad, inc, den;
        logic signed [63:0] tgt, d;
        logic [127:0]       prod, q;
        logic               neg;
        rate_result_t       r;
        rtt  = a.rtt;
        sig  = a.sig;
        now  = a.now;
        base = (a.base == 0) ? 64'd1 : a.base;
        if (!have_first)
        begin
            prev_sig   = sig;
            have_first = 1'b1;
        end
        neg = sig < prev_sig;
        mag = neg ? prev_sig - sig : sig - prev_sig;
        if (neg)
        begin
            if (neg_run < 255)
                neg_run = neg_run + 1;
        end
        else
            neg_run = 0;
        if (mag > MAG_CAP)
            mag = MAG_CAP;
        tgt = $signed(mag << FRAC_BITS);
        if (neg)
            tgt = -tgt;
        d    = tgt - avg_diff;
        dm   = (d < 0) ? -d : d;
        corr = mul_shift(dm, w_ewma, WEIGHT_BITS);
        if (d < 0)
            avg_diff = avg_diff - $signed(corr);
        else
            avg_diff = avg_diff + $signed(corr);

        if (now <= last_time)
            df = 0;
        else if (now - last_time >= base)
            df = 64'd1 << FRAC_BITS;
        else
            df = frac_quot(now - last_time, base);

        prior_rate = cur_rate;
        rate       = prior_rate;
        if (rtt < thr_low)
        begin
            r.rule = RULE_LOW_INC;
            rate   = add_sat(rate, mul_shift(add_step, df, FRAC_BITS));
        end
        else if (rtt > thr_high)
        begin
            ratio  = frac_quot(rtt - thr_high, rtt);
            m      = mul_shift(df, ratio, FRAC_BITS);
            r.rule = RULE_HIGH_DEC;
            rate   = shrink(rate, m * w_dec);
        end
        else
        begin
            grad = (avg_diff > 0) ? $unsigned(avg_diff) / base : 64'd0;
            if (avg_diff <= 0 || grad <= EPS_Q)
            begin
                inc    = mul_shift(add_step, df, FRAC_BITS);
                r.rule = RULE_GRAD_INC;
                if (neg_run >= hyper_thr)
                    inc = (inc > RATE_SAT) ? RATE_SAT * 5 : inc * 5;
                rate = add_sat(rate, inc);
            end
            else
            begin
                r.rule = RULE_GRAD_DEC;
                if (grad > GRAD_MAX)
                    grad = GRAD_MAX;
                rate = shrink(rate, grad * w_dec);
            end
        end
        if (rate < (prior_rate >> 1))
            rate = prior_rate >> 1;
        prev_sig  = sig;
        last_time = now;
        cur_rate  = rate;

        prod = ({64'd0, rate} * {64'd0, rtt}) << 5;
        den  = 64'd1000000000 * ((pkt_bytes == 0) ? 64'd1 : pkt_bytes);
        q    = prod / {64'd0, den};
        if (q > 128'hffffffff)
            q = 128'hffffffff;
        if (q <= WIN_MIN)
            q = WIN_FLOOR;
        r.rate = rate[RATE_BITS-1:0];
        r.win  = q[WIN_BITS-1:0];
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [63:0] v);
        case (addr)
            REG_EWMA_WEIGHT:  w_ewma    = v & 64'hffff;
            REG_LOW_THRESH:   thr_low   = v & MAX40;
            REG_HIGH_THRESH:  thr_high  = v & MAX40;
            REG_ADD_STEP:     add_step  = v & MAX40;
            REG_DEC_WEIGHT:   w_dec     = v & 64'hffff;
            REG_HYPER_THRESH: hyper_thr = v & 64'hff;
            REG_PACKET_BYTES: pkt_bytes = v & 64'hffff;
            REG_INITIAL_RATE: init_rate = v & MAX40;
            default: ;
        endcase
    endfunction

    function automatic logic [63:0] rand40();
        return {$urandom, $urandom} & MAX40;
    endfunction

    function automatic ack_item_t make_ack();
        ack_item_t   a;
        logic [63:0] b, r, step;
        b = ($urandom_range(0, 9) == 0) ? {32'd0, $urandom} : $urandom_range(1000, 200000);
        if (b == 0)
            b = 1;
        case ($urandom_range(0, 9))
            0: gen_now = (gen_now > 5000) ? gen_now - $urandom_range(0, 5000) : gen_now;
            1: gen_now = rand40();
            default: gen_now = (gen_now + $urandom_range(0, 2 * b)) & MAX40;
        endcase
        if ($urandom_range(0, 9) == 0)
            gen_dir = -gen_dir;
        step = $urandom_range(0, 4000);
        case ($urandom_range(0, 9))
            0: r = rand40();
            1: r = (thr_low > 0) ? rand40() % thr_low : 64'd0;
            2: r = (thr_high >= thr_low) ? thr_low + rand40() % (thr_high - thr_low + 1) : rand40();
            3: r = (thr_high < MAX40) ? thr_high + 1 + rand40() % (MAX40 - thr_high) : MAX40;
            default:
            begin
                if (gen_dir > 0)
                    r = (gen_rtt + step) & MAX40;
                else
                    r = (gen_rtt > step) ? gen_rtt - step : 64'd0;
            end
        endcase
        gen_rtt = r;
        a.rtt   = r[TIME_BITS-1:0];
        a.sig   = ($urandom_range(0, 6) == 0) ? rand40() : r;
        a.now   = gen_now[TIME_BITS-1:0];
        a.base  = b[BASE_BITS-1:0];
        return a;
    endfunction

    task automatic push_ack(logic [63:0] rtt, logic [63:0] sig, logic [63:0] now, logic [63:0] base);
        ack_item_t a;
        a.rtt  = rtt[TIME_BITS-1:0];
        a.sig  = sig[TIME_BITS-1:0];
        a.now  = now[TIME_BITS-1:0];
        a.base = base[BASE_BITS-1:0];
        pending_acks.push_back(a);
    endtask

    task automatic wait_drained();
        while (pending_acks.size() != 0 || ack_ch.valid || rate_exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [63:0] v);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= v[CFG_DATA_BITS-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_reg(addr, {24'd0, v[CFG_DATA_BITS-1:0]});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all(logic [63:0] ew, logic [63:0] lo, logic [63:0] hi, logic [63:0] st,
                             logic [63:0] dw, logic [63:0] hy, logic [63:0] pk, logic [63:0] ir);
        write_reg(REG_EWMA_WEIGHT, ew);
        write_reg(REG_LOW_THRESH, lo);
        write_reg(REG_HIGH_THRESH, hi);
        write_reg(REG_ADD_STEP, st);
        write_reg(REG_DEC_WEIGHT, dw);
        write_reg(REG_HYPER_THRESH, hy);
        write_reg(REG_PACKET_BYTES, pk);
        write_reg(REG_INITIAL_RATE, ir);
        write_reg(REG_UNUSED, rand40());
    endtask

    task automatic random_acks(int n);
        repeat (n)
            pending_acks.push_back(make_ack());
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ack driver
    always @(posedge clk or negedge rst_n)
    begin : ack_driver
        ack_item_t nxt;
        if (!rst_n)
            ack_ch.valid <= 1'b0;
        else
        begin
            if (ack_ch.valid && ack_ch.ready)
            begin
                nxt.rtt  = ack_ch.rtt_ns;
                nxt.sig  = ack_ch.signal_ns;
                nxt.now  = ack_ch.now_ns;
                nxt.base = ack_ch.base_rtt_ns;
                rate_exp_q.push_back(timely_predict(nxt));
            end
            if (!ack_ch.valid || ack_ch.ready)
            begin
                if (pending_acks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_acks.pop_front();
                    ack_ch.valid       <= 1'b1;
                    ack_ch.rtt_ns      <= nxt.rtt;
                    ack_ch.signal_ns   <= nxt.sig;
                    ack_ch.now_ns      <= nxt.now;
                    ack_ch.base_rtt_ns <= nxt.base;
                end
                else
                    ack_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : res_monitor
        rate_result_t e;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (rate_exp_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected result rate=%0d win=%0d rule=%0d", $time,
                             res_ch.rate_bps, res_ch.window_q8, res_ch.rule_taken);
                end
                else
                begin
                    e = rate_exp_q.pop_front();
                    if (res_ch.rate_bps !== e.rate)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: rate_bps exp %0d got %0d", $time, e.rate, res_ch.rate_bps);
                    end
                    if (res_ch.window_q8 !== e.win)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: window_q8 exp %0d got %0d", $time, e.win, res_ch.window_q8);
                    end
                    if (res_ch.rule_taken !== e.rule)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: rule_taken exp %0d got %0d", $time, e.rule,
                                 res_ch.rule_taken);
                    end
                end
            end
            if (stall_req != stall_seen)
            begin
                stall_seen   <= stall_req;
                stall_left   <= STALL_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((ack_ch.valid && ack_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[timely_rate_update] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        ack_ch.valid       = 1'b0;
        ack_ch.rtt_ns      = '0;
        ack_ch.signal_ns   = '0;
        ack_ch.now_ns      = '0;
        ack_ch.base_rtt_ns = '0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.addr        = '0;
        cfg_ch.data        = '0;
        fail_count         = 0;
        idle_cycles        = 0;
        stall_req          = 0;
        stall_seen         = 0;
        send_idle_pct      = 33;
        recv_idle_pct      = 53;
        gen_now            = 0;
        gen_rtt            = 100000;
        gen_dir            = 1;
        w_ewma     = EWMA_WEIGHT_RST;
        thr_low    = LOW_THRESH_RST;
        thr_high   = HIGH_THRESH_RST;
        add_step   = ADD_STEP_RST;
        w_dec      = DEC_WEIGHT_RST;
        hyper_thr  = HYPER_RST;
        pkt_bytes  = PACKET_RST;
        init_rate  = RATE_INIT;
        have_first = 1'b0;
        prev_sig   = 0;
        avg_diff   = 0;
        neg_run    = 0;
        cur_rate   = RATE_INIT;
        last_time  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings
        push_ack(10000, 10000, 1000, 20000);
        push_ack(0, 0, 0, 20000);
        push_ack(MAX40, MAX40, MAX40, 32'hffffffff);
        push_ack(100000, 100000, MAX40, 20000);
        push_ack(100000, 0, 5000, 1);
        for (int k = 0; k < 4; k++)
            push_ack(100000 + k * 5000, 100000 + k * 5000, 20000 + k * 10000, 20000);
        for (int k = 0; k < 7; k++)
            push_ack(200000 - k * 3000, 200000 - k * 3000, 70000 + k * 10000, 20000);
        push_ack(200000, MAX40, 200000, 1);
        push_ack(64'd1 << 39, 64'd1 << 39, 300000, 50000);
        push_ack(499999, 0, 300001, 1);
        push_ack(500001, 500001, 400000, 100000);
        wait_drained();
        random_acks(100);
        // receiver holds off while acks keep coming
        repeat (40)
            pending_acks.push_back(make_ack());
        stall_req = stall_req + 1;
        wait_drained();
        random_acks(100);

        write_all(64'hffff, 0, 1, MAX40, 64'hffff, 0, 1, MAX40);
        random_acks(150);

        send_idle_pct = 53;
        recv_idle_pct = 33;
        write_all(0, MAX40, MAX40, 0, 0, 255, 65535, 0);
        random_acks(150);
        write_all($urandom_range(0, 65535), 30000, 300000, $urandom_range(0, 1000000000),
                  $urandom_range(0, 65535), $urandom_range(0, 8), $urandom_range(1, 65535),
                  rand40());
        random_acks(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all($urandom_range(0, 65535), $urandom_range(0, 100000), $urandom_range(100000, 900000),
                  rand40(), $urandom_range(0, 65535), $urandom_range(0, 8),
                  $urandom_range(1, 9000), rand40());
        random_acks(250);
        write_all(EWMA_WEIGHT_RST, LOW_THRESH_RST, HIGH_THRESH_RST, ADD_STEP_RST,
                  DEC_WEIGHT_RST, HYPER_RST, PACKET_RST, RATE_INIT);
        random_acks(250);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && rate_exp_q.size() == 0)
            $display("[timely_rate_update] OK");
        else
            $display("[timely_rate_update] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

@@ timely_rate_update.f @@
design/tru_pkg.sv
design/tru_ack_if.sv
design/tru_res_if.sv
design/tru_cfg_if.sv
design/tru_cfg.sv
design/tru_unit.sv
design/timely_rate_update.sv
tb/tb_timely_rate_update.sv
